/* src/trusted_key_table_unit_macros.svh */
// Assertion macros shared by the trusted key table RTL.
`ifndef TRUSTED_KEY_TABLE_UNIT_MACROS_SVH
`define TRUSTED_KEY_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define TKT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trusted key table assertion failed");
// Next-cycle implication, disabled during reset.
`define TKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trusted key table assertion failed");
`else
`define TKT_ASSERT_IMP(label, clk, rst, ante, cons)
`define TKT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/tkt_pkg.sv */
// Types and constants of the trusted key table.
package tkt_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int KEY_WORDS   = 6;
   localparam int WORD_W      = 64;
   localparam int KEY_W       = KEY_WORDS * WORD_W;
   localparam int IDX_W       = 5;
   localparam int CNT_W       = 6;
   localparam int SEL_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_DUP      = 3'd2,
      ST_PROT     = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_RANGE    = 3'd5
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      key_type key;
      logic    prot;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

/* src/tkt_req_if.sv */
// Request channel of the trusted key table.
interface tkt_req_if;
   import tkt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             action;
   logic [WORD_W-1:0]      key_word_0;
   logic [WORD_W-1:0]      key_word_1;
   logic [WORD_W-1:0]      key_word_2;
   logic [WORD_W-1:0]      key_word_3;
   logic [WORD_W-1:0]      key_word_4;
   logic [WORD_W-1:0]      key_word_5;
   logic                   protect_in;
   logic [IDX_W-1:0]       entry_index;

   modport source (
      output valid, action, key_word_0, key_word_1, key_word_2, key_word_3,
             key_word_4, key_word_5, protect_in, entry_index,
      input  ready
   );
   modport sink (
      input  valid, action, key_word_0, key_word_1, key_word_2, key_word_3,
             key_word_4, key_word_5, protect_in, entry_index,
      output ready
   );
endinterface

/* src/tkt_rsp_if.sv */
// Response channel of the trusted key table.
interface tkt_rsp_if;
   import tkt_pkg::*;

   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic               found;
   logic [WORD_W-1:0]  out_word_0;
   logic [WORD_W-1:0]  out_word_1;
   logic [WORD_W-1:0]  out_word_2;
   logic [WORD_W-1:0]  out_word_3;
   logic [WORD_W-1:0]  out_word_4;
   logic [WORD_W-1:0]  out_word_5;
   logic               protect_out;
   logic [CNT_W-1:0]   entry_count;

   modport source (
      output valid, status, found, out_word_0, out_word_1, out_word_2, out_word_3,
             out_word_4, out_word_5, protect_out, entry_count,
      input  ready
   );
   modport sink (
      input  valid, status, found, out_word_0, out_word_1, out_word_2, out_word_3,
             out_word_4, out_word_5, protect_out, entry_count,
      output ready
   );
endinterface

/* src/tkt_cell.sv */
// One table cell: holds an entry, compares it and shifts from its upper neighbour.
module tkt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  occupied,
   input  logic                  cmp_en,
   input  tkt_pkg::key_type      cmp_key,
   input  tkt_pkg::cell_ctrl_type ctrl,
   input  tkt_pkg::entry_type    new_entry,
   input  tkt_pkg::entry_type    upper_entry,
   input  logic                  chain_in,
   output tkt_pkg::entry_type    entry,
   output logic                  match,
   output logic                  chain_out
);
   import tkt_pkg::*;

   entry_type entry_ff, entry_in;
   logic      match_ff, match_in;

   // Latch the compare result when a transaction is taken
   assign match_in  = cmp_en ? (occupied && (entry_ff.key == cmp_key)) : match_ff;
   // Cells at or above the matching one move down on removal
   assign chain_out = chain_in | match_ff;

   always_comb begin
      priority if (ctrl.load) begin
         entry_in = new_entry;
      end else if (ctrl.shift && chain_out) begin
         entry_in = upper_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;
endmodule

/* src/trusted_key_table_unit.sv */
// Top level of the trusted key table: control, cell row and response register.
`include "trusted_key_table_unit_macros.svh"
// Usage:
//   req_bus carries one transaction per request: action (add, remove, lookup,
//   read by index), the 384-bit key as six 64-bit words, a protect flag and
//   an index. rsp_bus returns exactly one transaction per request with a
//   status, the found flag, the read-back key and flag, and the entry count.
// Sequencing:
//   A request is taken in the idle state and executed in the execute state
//   once the output register is free; the response is valid the cycle after
//   execution. In the cycle a request is taken every occupied cell compares
//   its key against the request key in parallel; on execution the row is
//   updated (append, or a one-step shift down of all cells above a removed
//   entry). A new request is not taken until the previous one has executed.
// Reset:
//   Synchronous, active high. Clears the entry count, the state machine and
//   the response valid; cell contents are left as they are and are only
//   read below the count.
// Stall:
//   A finished response waits in the output register. A new request is still
//   taken; its execution holds until the output register is free.
module trusted_key_table_unit (
   input logic        clock,
   input logic        reset,
   tkt_req_if.sink    req_bus,
   tkt_rsp_if.source  rsp_bus
);
   import tkt_pkg::*;

   // ---------------------------------------------------------------- control
   state_type         state_ff, state_in;
   logic              req_accept;
   logic              commit;

   // Held request fields
   action_type        action_ff;
   key_type           key_ff;
   logic              prot_ff;
   logic [IDX_W-1:0]  index_ff;

   logic [CNT_W-1:0]  count_ff, count_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic              found_ff, found_in;
   key_type           out_key_ff, out_key_in;
   logic              prot_out_ff, prot_out_in;
   logic [CNT_W-1:0]  rsp_count_ff;

   // Cell row
   key_type           req_key;
   entry_type         entries    [MAX_ENTRIES];
   entry_type         new_entry;
   cell_ctrl_type     cell_ctrl  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] match_vec;
   logic [MAX_ENTRIES-1:0] prot_vec;
   logic [MAX_ENTRIES:0]   chain;
   logic              any_match;
   logic              prot_hit;
   logic              add_ok;
   logic              remove_ok;
   logic              in_range;
   entry_type         read_entry;

   assign req_key = {req_bus.key_word_0, req_bus.key_word_1, req_bus.key_word_2,
                     req_bus.key_word_3, req_bus.key_word_4, req_bus.key_word_5};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State outputs: take requests when idle, execute once the response slot is free
   always_comb begin
      req_bus.ready = 1'b0;
      commit        = 1'b0;
      unique case (state_ff)
         S_IDLE: req_bus.ready = 1'b1;
         S_EXEC: commit = !rsp_valid_ff || rsp_bus.ready;
         default: begin
            req_bus.ready = 1'b0;
            commit        = 1'b0;
         end
      endcase
   end

   assign req_accept = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request for the execute cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff <= action_type'(req_bus.action);
         key_ff    <= req_key;
         prot_ff   <= req_bus.protect_in;
         index_ff  <= req_bus.entry_index;
      end
   end

   // ---------------------------------------------------------------- cell row
   assign new_entry = '{key: key_ff, prot: prot_ff};
   assign chain[0]  = 1'b0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type upper;
      if (i == MAX_ENTRIES - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = entries[i+1];
      end

      assign cell_ctrl[i].load  = commit && add_ok && (count_ff == CNT_W'(i));
      assign cell_ctrl[i].shift = commit && remove_ok;
      assign prot_vec[i]        = match_vec[i] && entries[i].prot;

      tkt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .occupied    (CNT_W'(i) < count_ff),
         .cmp_en      (req_accept),
         .cmp_key     (req_key),
         .ctrl        (cell_ctrl[i]),
         .new_entry   (new_entry),
         .upper_entry (upper),
         .chain_in    (chain[i]),
         .entry       (entries[i]),
         .match       (match_vec[i]),
         .chain_out   (chain[i+1])
      );
   end

   assign any_match  = |match_vec;
   assign prot_hit   = |prot_vec;
   assign in_range   = CNT_W'(index_ff) < count_ff;
   assign read_entry = entries[SEL_W'(index_ff)];

   // ---------------------------------------------------------------- execute
   always_comb begin
      add_ok      = 1'b0;
      remove_ok   = 1'b0;
      status_in   = ST_OK;
      found_in    = 1'b0;
      out_key_in  = '0;
      prot_out_in = 1'b0;
      unique case (action_ff)
         ACT_ADD: begin
            priority if (count_ff >= CNT_W'(MAX_ENTRIES)) status_in = ST_FULL;
            else if (any_match) status_in = ST_DUP;
            else add_ok = 1'b1;
         end
         ACT_REMOVE: begin
            priority if (!any_match) status_in = ST_NOTFOUND;
            else if (prot_hit) status_in = ST_PROT;
            else remove_ok = 1'b1;
         end
         ACT_LOOKUP: found_in = any_match;
         ACT_READ: begin
            if (in_range) begin
               out_key_in  = read_entry.key;
               prot_out_in = read_entry.prot;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (commit && add_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (commit && remove_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Advance the response register on execute; drop valid once taken
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         out_key_ff   <= out_key_in;
         prot_out_ff  <= prot_out_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.found       = found_ff;
   assign rsp_bus.out_word_0  = out_key_ff[6*WORD_W-1:5*WORD_W];
   assign rsp_bus.out_word_1  = out_key_ff[5*WORD_W-1:4*WORD_W];
   assign rsp_bus.out_word_2  = out_key_ff[4*WORD_W-1:3*WORD_W];
   assign rsp_bus.out_word_3  = out_key_ff[3*WORD_W-1:2*WORD_W];
   assign rsp_bus.out_word_4  = out_key_ff[2*WORD_W-1:WORD_W];
   assign rsp_bus.out_word_5  = out_key_ff[WORD_W-1:0];
   assign rsp_bus.protect_out = prot_out_ff;
   assign rsp_bus.entry_count = rsp_count_ff;

   // ---------------------------------------------------------------- checks
   `TKT_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES))
   `TKT_ASSERT_IMP(a_match_unique, clock, reset, 1'b1, $onehot0(match_vec))
   `TKT_ASSERT_NEXT(a_commit_rsp, clock, reset, commit, rsp_valid_ff)
   `TKT_ASSERT_NEXT(a_accept_exec, clock, reset, req_accept, state_ff == S_EXEC)

endmodule
